>>> hw/rtl/klt_pkg.sv
// Shared types and codes for the keyed lock table.
`timescale 1ns / 1ps

package klt_pkg;

    // Slot indexes travel at this width between modules; up to 64 slots.
    localparam int SLOT_ID_W = 6;
    localparam int KEY_W     = 16;
    localparam int THREAD_W  = 4;
    localparam int STATUS_W  = 3;
    localparam int SLOT_OUT_W = 3;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACQUIRED = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_FREED    = 3'd2,
        ST_HANDED   = 3'd3,
        ST_NOSLOT   = 3'd4,
        ST_QFULL    = 3'd5
    } t_status;

    typedef struct packed {
        logic                 held_hit;
        logic [SLOT_ID_W-1:0] held_idx;
        logic                 free_hit;
        logic [SLOT_ID_W-1:0] free_idx;
    } t_cam_match;

    typedef struct packed {
        logic                 set_busy;
        logic                 clr_busy;
        logic [SLOT_ID_W-1:0] idx;
    } t_cam_update;

endpackage

>>> hw/rtl/klt_slot_cam.sv
// Slot key store with parallel key match and lowest-free-slot search.
`timescale 1ns / 1ps

module klt_slot_cam #(
    parameter int NUM_SLOTS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [klt_pkg::KEY_W-1:0]  i_key,
    output klt_pkg::t_cam_match        o_match,
    input  klt_pkg::t_cam_update       i_upd,
    input  logic [klt_pkg::KEY_W-1:0]  i_upd_key
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [klt_pkg::KEY_W-1:0] r_slot_key [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]      r_slot_busy;
    logic [SW-1:0]             upd_idx;

    assign upd_idx = i_upd.idx[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_busy <= '0;
        end else if (i_upd.set_busy) begin
            r_slot_busy[upd_idx] <= 1'b1;
        end else if (i_upd.clr_busy) begin
            r_slot_busy[upd_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.set_busy) begin
            r_slot_key[upd_idx] <= i_upd_key;
        end
    end

    // Scan from the top so that the lowest matching or free slot wins.
    always_comb begin
        o_match = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_slot_busy[i] && (r_slot_key[i] == i_key)) begin
                o_match.held_hit = 1'b1;
                o_match.held_idx = klt_pkg::SLOT_ID_W'(i);
            end
            if (!r_slot_busy[i]) begin
                o_match.free_hit = 1'b1;
                o_match.free_idx = klt_pkg::SLOT_ID_W'(i);
            end
        end
    end

endmodule

>>> hw/rtl/keyed_lock_table.sv
// Keyed lock table: lock slots with per-slot FIFO wait queues.
// A command is captured when accepted, worked in the busy cycle, and its result registered onto o_valid.
// A new command is not taken while busy; busy is high for the one cycle in which the
// queue pointer memory is read-modified-written and the wait memory is accessed.
// Reset clears the slot busy bits at once; no clearing pass, start is taken right after.
// The receiver cannot stall: each result is shown for exactly one cycle on o_valid.
`timescale 1ns / 1ps

module keyed_lock_table #(
    parameter int NUM_SLOTS   = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [klt_pkg::KEY_W-1:0]     i_lock_key,
    input  logic [klt_pkg::THREAD_W-1:0]  i_caller_thread,
    output logic                          o_valid,
    output logic [klt_pkg::STATUS_W-1:0]  o_status,
    output logic [klt_pkg::THREAD_W-1:0]  o_woken_thread,
    output logic [klt_pkg::SLOT_OUT_W-1:0] o_slot_index
);

    localparam int SW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int HCW  = QW + CW;
    localparam int FAW  = SW + QW;

    // Control
    logic r_work;
    logic r_out_valid;
    logic accept;

    // Command captured at accept
    logic                          r_op;
    logic [klt_pkg::KEY_W-1:0]     r_key;
    logic [klt_pkg::THREAD_W-1:0]  r_caller;
    klt_pkg::t_cam_match           r_match;

    // Queue pointer memory: head and count for each slot
    logic [HCW-1:0] hc_mem [NUM_SLOTS];
    logic [HCW-1:0] r_hc_rd;
    logic           hc_we;
    logic [HCW-1:0] hc_wdata;

    // Wait queue memory
    logic [klt_pkg::THREAD_W-1:0] fifo_mem [2**FAW];
    logic [klt_pkg::THREAD_W-1:0] r_fifo_rd;
    logic                         fifo_we;
    logic                         fifo_re;
    logic [FAW-1:0]               fifo_addr;

    // Match and work-cycle signals
    klt_pkg::t_cam_match  cam_match;
    klt_pkg::t_cam_update cam_upd;
    logic [SW-1:0]        rd_slot;
    logic [SW-1:0]        sel_slot;
    logic [QW-1:0]        head;
    logic [CW-1:0]        count;
    logic [CW:0]          tail_sum;
    logic [QW-1:0]        tail;
    logic [QW-1:0]        head_next;
    logic                 queue_full;
    klt_pkg::t_status     n_status;
    logic                 n_report_slot;
    logic [SW+2:0]        slot_ext;

    // Result registers
    logic [klt_pkg::STATUS_W-1:0]   r_status;
    logic [klt_pkg::SLOT_OUT_W-1:0] r_slot;
    logic                           r_handed;

    assign accept = start && !r_work;
    assign busy   = r_work;

    klt_slot_cam #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_cam (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (i_lock_key),
        .o_match   (cam_match),
        .i_upd     (cam_upd),
        .i_upd_key (r_key)
    );

    assign rd_slot = cam_match.held_hit ? cam_match.held_idx[SW-1:0]
                                        : cam_match.free_idx[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_work      <= accept;
            r_out_valid <= r_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_opcode;
            r_key    <= i_lock_key;
            r_caller <= i_caller_thread;
            r_match  <= cam_match;
        end
    end

    // The pointer read issued at accept lands in time for the work cycle; its write
    // back ends the work cycle, before the next accept can read again.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hc_rd <= hc_mem[rd_slot];
        end
        if (hc_we) begin
            hc_mem[sel_slot] <= hc_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            fifo_mem[fifo_addr] <= r_caller;
        end
        if (fifo_re) begin
            r_fifo_rd <= fifo_mem[fifo_addr];
        end
    end

    assign sel_slot   = r_match.held_hit ? r_match.held_idx[SW-1:0] : r_match.free_idx[SW-1:0];
    assign head       = r_hc_rd[HCW-1:CW];
    assign count      = r_hc_rd[CW-1:0];
    assign queue_full = (count >= CW'(QUEUE_DEPTH));

    // head < depth and count < depth when not full, so one subtract wraps the tail.
    assign tail_sum  = (CW+1)'(head) + (CW+1)'(count);
    assign tail      = (tail_sum >= (CW+1)'(QUEUE_DEPTH))
                       ? QW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
    assign head_next = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(head + QW'(1));

    always_comb begin
        hc_we         = 1'b0;
        hc_wdata      = '0;
        fifo_we       = 1'b0;
        fifo_re       = 1'b0;
        fifo_addr     = {sel_slot, tail};
        cam_upd       = '0;
        cam_upd.idx   = klt_pkg::SLOT_ID_W'(sel_slot);
        n_status      = klt_pkg::ST_NOSLOT;
        n_report_slot = 1'b0;
        if (r_work) begin
            if (r_op == klt_pkg::OP_ACQUIRE) begin
                if (r_match.held_hit) begin
                    n_report_slot = 1'b1;
                    if (queue_full) begin
                        n_status = klt_pkg::ST_QFULL;
                    end else begin
                        n_status = klt_pkg::ST_QUEUED;
                        fifo_we  = 1'b1;
                        hc_we    = 1'b1;
                        hc_wdata = {head, CW'(count + CW'(1))};
                    end
                end else if (r_match.free_hit) begin
                    n_status         = klt_pkg::ST_ACQUIRED;
                    n_report_slot    = 1'b1;
                    cam_upd.set_busy = 1'b1;
                    hc_we            = 1'b1;
                    hc_wdata         = '0;
                end
            end else if (r_match.held_hit) begin
                n_report_slot = 1'b1;
                hc_we         = 1'b1;
                if (count != '0) begin
                    n_status  = klt_pkg::ST_HANDED;
                    fifo_re   = 1'b1;
                    fifo_addr = {sel_slot, head};
                    hc_wdata  = {head_next, CW'(count - CW'(1))};
                end else begin
                    n_status         = klt_pkg::ST_FREED;
                    cam_upd.clr_busy = 1'b1;
                    hc_wdata         = {QW'(0), count};
                end
            end
        end
    end

    assign slot_ext = {3'b000, sel_slot};

    always_ff @(posedge i_clk) begin
        if (r_work) begin
            r_status <= n_status;
            r_slot   <= n_report_slot ? slot_ext[2:0] : '0;
            r_handed <= (n_status == klt_pkg::ST_HANDED);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_slot_index   = r_slot;
    assign o_woken_thread = r_handed ? r_fifo_rd : '0;

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not enter the work cycle");

    a_result_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("work cycle produced no result beat");

    a_woken_only_on_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != klt_pkg::ST_HANDED)) |-> (o_woken_thread == '0))
        else $error("woken thread reported without a handoff");

    a_noslot_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == klt_pkg::ST_NOSLOT)) |-> (o_slot_index == '0))
        else $error("slot index reported on a failed command");

endmodule

>>> dv/tb_keyed_lock_table.sv
// Testbench for the keyed lock table: directed and random lock traffic checked beat by beat.
`timescale 1ns / 1ps

module tb_keyed_lock_table;

    localparam int NUM_SLOTS    = 8;
    localparam int QUEUE_DEPTH  = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 16;

    typedef struct {
        klt_pkg::t_status               status;
        logic [klt_pkg::THREAD_W-1:0]   woken;
        logic [klt_pkg::SLOT_OUT_W-1:0] slot;
    } t_lock_reply;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic                           i_opcode = klt_pkg::OP_ACQUIRE;
    logic [klt_pkg::KEY_W-1:0]      i_lock_key = '0;
    logic [klt_pkg::THREAD_W-1:0]   i_caller_thread = '0;
    logic                           o_valid;
    logic [klt_pkg::STATUS_W-1:0]   o_status;
    logic [klt_pkg::THREAD_W-1:0]   o_woken_thread;
    logic [klt_pkg::SLOT_OUT_W-1:0] o_slot_index;

    // Mirror of the lock table as the block should hold it.
    logic [klt_pkg::KEY_W-1:0]    held_key [NUM_SLOTS];
    bit                           held [NUM_SLOTS];
    logic [klt_pkg::THREAD_W-1:0] waiters [NUM_SLOTS][QUEUE_DEPTH];
    int unsigned                  wait_head [NUM_SLOTS];
    int unsigned                  wait_count [NUM_SLOTS];

    t_lock_reply reply_q[$];
    int          errors = 0;
    int          idle_cycles = 0;

    keyed_lock_table #(
        .NUM_SLOTS  (NUM_SLOTS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_lock_key     (i_lock_key),
        .i_caller_thread(i_caller_thread),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_woken_thread (o_woken_thread),
        .o_slot_index   (o_slot_index)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_lock_reply apply_lock_command(logic op,
                                                       logic [klt_pkg::KEY_W-1:0] key,
                                                       logic [klt_pkg::THREAD_W-1:0] thread);
        t_lock_reply r;
        int          hit;
        int          vacant;
        r.status = klt_pkg::ST_NOSLOT;
        r.woken  = '0;
        r.slot   = '0;
        hit      = -1;
        vacant   = -1;
        // Scan downward so that the lowest matching and lowest free slot win.
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (held[i] && held_key[i] == key) hit = i;
            if (!held[i]) vacant = i;
        end
        if (op == klt_pkg::OP_ACQUIRE) begin
            if (hit >= 0) begin
                r.slot = klt_pkg::SLOT_OUT_W'(hit);
                if (wait_count[hit] >= QUEUE_DEPTH) begin
                    r.status = klt_pkg::ST_QFULL;
                end else begin
                    waiters[hit][(wait_head[hit] + wait_count[hit]) % QUEUE_DEPTH] = thread;
                    wait_count[hit]++;
                    r.status = klt_pkg::ST_QUEUED;
                end
            end else if (vacant >= 0) begin
                held[vacant]       = 1'b1;
                held_key[vacant]   = key;
                wait_head[vacant]  = 0;
                wait_count[vacant] = 0;
                r.status = klt_pkg::ST_ACQUIRED;
                r.slot   = klt_pkg::SLOT_OUT_W'(vacant);
            end
        end else if (hit >= 0) begin
            r.slot = klt_pkg::SLOT_OUT_W'(hit);
            if (wait_count[hit] > 0) begin
                r.woken        = waiters[hit][wait_head[hit]];
                wait_head[hit] = (wait_head[hit] + 1) % QUEUE_DEPTH;
                wait_count[hit]--;
                r.status = klt_pkg::ST_HANDED;
            end else begin
                held[hit]      = 1'b0;
                wait_head[hit] = 0;
                r.status = klt_pkg::ST_FREED;
            end
        end
        return r;
    endfunction

    function automatic int pick_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Start stays high from one beat to the next when there is no gap.
    task automatic send_command(logic op, logic [klt_pkg::KEY_W-1:0] key,
                                logic [klt_pkg::THREAD_W-1:0] thread, int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode        = op;
        i_lock_key      = key;
        i_caller_thread = thread;
        start           = 1'b1;
        do @(posedge i_clk); while (busy);
        reply_q.push_back(apply_lock_command(op, key, thread));
    endtask

    task automatic test_grant_and_free();
        send_command(klt_pkg::OP_ACQUIRE, 16'h0000, 4'd0, pick_gap(0));
        send_command(klt_pkg::OP_RELEASE, 16'h0000, 4'd9, pick_gap(0));
        send_command(klt_pkg::OP_RELEASE, 16'h0000, 4'd0, pick_gap(0));
        send_command(klt_pkg::OP_ACQUIRE, 16'hFFFF, 4'd15, pick_gap(0));
        send_command(klt_pkg::OP_ACQUIRE, 16'hFFFF, 4'd5, pick_gap(0));
        // The holder asking again is simply queued behind the thread already waiting.
        send_command(klt_pkg::OP_ACQUIRE, 16'hFFFF, 4'd15, pick_gap(0));
        send_command(klt_pkg::OP_RELEASE, 16'hFFFF, 4'd0, pick_gap(0));
        send_command(klt_pkg::OP_RELEASE, 16'hFFFF, 4'd0, pick_gap(0));
        send_command(klt_pkg::OP_RELEASE, 16'hFFFF, 4'd0, pick_gap(0));
    endtask

    task automatic test_queue_full();
        send_command(klt_pkg::OP_ACQUIRE, 16'h8001, 4'd1, pick_gap(1));
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_command(klt_pkg::OP_ACQUIRE, 16'h8001, 4'(i ^ 5), pick_gap(1));
        send_command(klt_pkg::OP_ACQUIRE, 16'h8001, 4'd7, pick_gap(0));
    endtask

    task automatic test_table_full();
        for (int i = 1; i < NUM_SLOTS; i++)
            send_command(klt_pkg::OP_ACQUIRE, 16'(16'h1111 * i), 4'(i), pick_gap(0));
        send_command(klt_pkg::OP_ACQUIRE, 16'h5AA5, 4'd3, pick_gap(0));
        send_command(klt_pkg::OP_RELEASE, 16'h3333, 4'd0, pick_gap(0));
        send_command(klt_pkg::OP_ACQUIRE, 16'hA55A, 4'd12, pick_gap(0));
    endtask

    // Keys come mostly from a small pool that includes every key held when the pool is built, so grants,
    // queueing, handoffs and full tables all keep happening.
    task automatic test_random_traffic();
        logic [klt_pkg::KEY_W-1:0] pool[$];
        int                        pool_size;
        int                        acquire_pct;
        bit                        quiet;
        logic [klt_pkg::KEY_W-1:0] key;
        logic                      op;
        for (int p = 0; p < 5; p++) begin
            quiet       = (p == 1) || ($urandom_range(0, 3) == 0);
            pool_size   = (p == 2) ? 2 : $urandom_range(3, 12);
            acquire_pct = (p == 2) ? 75 : $urandom_range(40, 70);
            pool.delete();
            for (int s = 0; s < NUM_SLOTS; s++)
                if (held[s]) pool.push_back(held_key[s]);
            while (pool.size() < pool_size) begin
                case ($urandom_range(0, 5))
                    0:       pool.push_back(16'h0000);
                    1:       pool.push_back(16'hFFFF);
                    default: pool.push_back(klt_pkg::KEY_W'($urandom_range(0, 65535)));
                endcase
            end
            for (int n = 0; n < 95; n++) begin
                if ($urandom_range(0, 19) == 0)
                    key = klt_pkg::KEY_W'($urandom_range(0, 65535));
                else if (p == 2)
                    key = pool[$urandom_range(0, 1)];
                else
                    key = pool[$urandom_range(0, pool.size() - 1)];
                op = ($urandom_range(0, 99) < acquire_pct) ? klt_pkg::OP_ACQUIRE
                                                           : klt_pkg::OP_RELEASE;
                send_command(op, key, klt_pkg::THREAD_W'($urandom_range(0, 15)),
                             pick_gap(quiet));
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_lock_reply want;
        if (i_rst_n && o_valid) begin
            if (reply_q.size() == 0) begin
                $error("result with none pending: status %0d slot %0d", o_status, o_slot_index);
                errors++;
            end else begin
                want = reply_q.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_woken_thread !== want.woken) begin
                    $error("woken_thread: expected %0d, got %0d", want.woken, o_woken_thread);
                    errors++;
                end
                if (o_slot_index !== want.slot) begin
                    $error("slot_index: expected %0d, got %0d", want.slot, o_slot_index);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            held[s]       = 1'b0;
            held_key[s]   = '0;
            wait_head[s]  = 0;
            wait_count[s] = 0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_grant_and_free();
        test_queue_full();
        test_table_full();
        test_random_traffic();

        @(negedge i_clk);
        start = 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
